>>> hdl/fmdc_pkg.sv
// ============================================================================
// fmdc_pkg
// Shared types and codes for the flow metered dosing controller.
// ============================================================================
package fmdc_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int COUNT_W     = 24;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_ABORT  = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_NONE    = 3'd0,
    ST_TARGET  = 3'd1,
    ST_TIMEOUT = 3'd2,
    ST_NO_FLOW = 3'd3,
    ST_ABORTED = 3'd4,
    ST_IGNORED = 3'd5
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PULSES_PER_UNIT = 3'd0,
    REG_PULSE_OFFSET    = 3'd1,
    REG_UNITS_PER_PULSE = 3'd2,
    REG_TIMEOUT         = 3'd3,
    REG_NO_FLOW_AFTER   = 3'd4
  } reg_index_t;

  // Item after the input stage: start target already scaled
  typedef struct packed {
    logic [1:0]         operation;
    logic               valve_select;
    logic [15:0]        window_pulses;
    logic [31:0]        now_us;
    logic [COUNT_W-1:0] target;
  } prep_t;

  // Item after the decision stage, volume still to be scaled
  typedef struct packed {
    logic               driver_enable;
    logic               valve_a_open;
    logic               valve_b_open;
    logic               finished;
    status_t            status;
    logic [COUNT_W-1:0] pulse_total;
  } core_res_t;

endpackage

>>> hdl/fmdc_ifs.sv
// ============================================================================
// fmdc_ifs
// Command and result channels: valid/ready handshake with payload.
// ============================================================================
interface fmdc_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] target_volume;
  logic        valve_select;
  logic [15:0] window_pulses;
  logic [31:0] now_us;

  modport source (output valid, operation, target_volume, valve_select,
                  window_pulses, now_us, input ready);
  modport sink (input valid, operation, target_volume, valve_select,
                window_pulses, now_us, output ready);
endinterface

interface fmdc_res_if;
  logic        valid;
  logic        ready;
  logic        driver_enable;
  logic        pump_on;
  logic        valve_a_open;
  logic        valve_b_open;
  logic        finished;
  logic [2:0]  status;
  logic [15:0] volume_delivered;
  logic [23:0] pulse_total;

  modport source (output valid, driver_enable, pump_on, valve_a_open, valve_b_open,
                  finished, status, volume_delivered, pulse_total, input ready);
  modport sink (input valid, driver_enable, pump_on, valve_a_open, valve_b_open,
                finished, status, volume_delivered, pulse_total, output ready);
endinterface

>>> hdl/fmdc_prep.sv
// ============================================================================
// fmdc_prep
// Input register; scales the requested volume into a pulse target.
// ============================================================================
module fmdc_prep (
  input  logic                             clk,
  input  logic                             rst,
  fmdc_cmd_if.sink                         cmd,
  input  logic [23:0]                      pulses_per_unit_q16,
  input  logic [23:0]                      pulse_offset_q16,
  output logic                             out_valid,
  output fmdc_pkg::prep_t                  out_data,
  input  logic                             out_ready
);
  import fmdc_pkg::*;

  logic [39:0]        prod;
  logic [39:0]        diff;
  logic [COUNT_W-1:0] target;

  // Truncate (gain*volume - offset) to whole pulses, floor at zero
  assign prod   = 40'(pulses_per_unit_q16) * 40'(cmd.target_volume);
  assign diff   = prod - 40'(pulse_offset_q16);
  assign target = (prod > 40'(pulse_offset_q16)) ? diff[39:16] : '0;

  assign cmd.ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.ready) begin
      out_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      out_data.operation     <= cmd.operation;
      out_data.valve_select  <= cmd.valve_select;
      out_data.window_pulses <= cmd.window_pulses;
      out_data.now_us        <= cmd.now_us;
      out_data.target        <= target;
    end
  end
endmodule

>>> hdl/fmdc_core.sv
// ============================================================================
// fmdc_core
// Run state and end-of-run decisions, one item per cycle unless out_ready stalls.
// ============================================================================
module fmdc_core (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [31:0]              timeout_us,
  input  logic [31:0]              no_flow_after_us,
  input  logic                     in_valid,
  input  fmdc_pkg::prep_t          in_data,
  output logic                     in_ready,
  output logic                     out_valid,
  output fmdc_pkg::core_res_t      out_data,
  input  logic                     out_ready
);
  import fmdc_pkg::*;

  logic               running;
  logic               selected_valve;
  logic [COUNT_W-1:0] pulse_count;
  logic [COUNT_W-1:0] pulse_target;
  logic [31:0]        start_time;

  logic               running_next;
  logic               selected_valve_next;
  logic [COUNT_W-1:0] pulse_count_next;
  logic [COUNT_W-1:0] pulse_target_next;
  logic [31:0]        start_time_next;
  logic               fin;
  status_t            status;

  logic [31:0]        elapsed;
  logic [COUNT_W:0]   sum;
  logic [COUNT_W-1:0] sat_count;
  logic               dry;
  logic               fire;

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;

  assign elapsed   = in_data.now_us - start_time;
  assign sum       = {1'b0, pulse_count} + (COUNT_W+1)'(in_data.window_pulses);
  assign sat_count = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
  assign dry       = (in_data.window_pulses == '0) && (elapsed >= no_flow_after_us);

  always_comb begin
    running_next        = running;
    selected_valve_next = selected_valve;
    pulse_count_next    = pulse_count;
    pulse_target_next   = pulse_target;
    start_time_next     = start_time;
    fin                 = 1'b0;
    status              = ST_IGNORED;
    case (op_t'(in_data.operation))
      OP_START: begin
        if (!running) begin
          selected_valve_next = in_data.valve_select;
          pulse_count_next    = '0;
          pulse_target_next   = in_data.target;
          start_time_next     = in_data.now_us;
          if (in_data.target == '0) begin
            fin    = 1'b1;
            status = ST_TARGET;
          end else begin
            running_next = 1'b1;
            status       = ST_NONE;
          end
        end
      end
      OP_SAMPLE: begin
        if (running) begin
          pulse_count_next = sat_count;
          // Target beats no flow, no flow beats timeout
          if (sat_count >= pulse_target) begin
            running_next = 1'b0;
            fin          = 1'b1;
            status       = ST_TARGET;
          end else if (dry) begin
            running_next = 1'b0;
            fin          = 1'b1;
            status       = ST_NO_FLOW;
          end else if (elapsed >= timeout_us) begin
            running_next = 1'b0;
            fin          = 1'b1;
            status       = ST_TIMEOUT;
          end else begin
            status = ST_NONE;
          end
        end
      end
      OP_ABORT: begin
        if (running) begin
          running_next = 1'b0;
          fin          = 1'b1;
          status       = ST_ABORTED;
        end
      end
      default: begin
        status = ST_IGNORED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running        <= 1'b0;
      selected_valve <= 1'b0;
      pulse_count    <= '0;
      pulse_target   <= '0;
      start_time     <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (fire) begin
        running        <= running_next;
        selected_valve <= selected_valve_next;
        pulse_count    <= pulse_count_next;
        pulse_target   <= pulse_target_next;
        start_time     <= start_time_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data.driver_enable <= running_next;
      out_data.valve_a_open  <= running_next && !selected_valve_next;
      out_data.valve_b_open  <= running_next && selected_valve_next;
      out_data.finished      <= fin;
      out_data.status        <= status;
      out_data.pulse_total   <= pulse_count_next;
    end
  end
endmodule

>>> hdl/fmdc_vol.sv
// ============================================================================
// fmdc_vol
// Output register; scales the final pulse count into delivered volume.
// ============================================================================
module fmdc_vol (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [15:0]              units_per_pulse_q16,
  input  logic                     in_valid,
  input  fmdc_pkg::core_res_t      in_data,
  output logic                     in_ready,
  fmdc_res_if.source               res
);
  import fmdc_pkg::*;

  logic [39:0] vprod;
  logic [15:0] volume;

  // Drop the fraction, saturate to 16 bits
  assign vprod  = 40'(in_data.pulse_total) * 40'(units_per_pulse_q16);
  assign volume = (vprod[39:32] != '0) ? 16'hFFFF : vprod[31:16];

  assign in_ready = !res.valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (in_ready) begin
      res.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      res.driver_enable    <= in_data.driver_enable;
      res.pump_on          <= in_data.driver_enable;
      res.valve_a_open     <= in_data.valve_a_open;
      res.valve_b_open     <= in_data.valve_b_open;
      res.finished         <= in_data.finished;
      res.status           <= in_data.status;
      res.volume_delivered <= in_data.finished ? volume : '0;
      res.pulse_total      <= in_data.pulse_total;
    end
  end
endmodule

>>> hdl/flow_metered_dosing_controller.sv
// Pipeline: a command passes through the input, decision and output registers
//   before its result is presented on res.
// Throughput: one command per cycle unless res.ready stalls; run state updates per command.
// Reset: synchronous, active high; clears the run state, empties all stages
//   and loads the calibration registers with their default values.
// ============================================================================
// flow_metered_dosing_controller
// Batch dosing controller driven by flow meter sample windows.
// ============================================================================
module flow_metered_dosing_controller (
  input  logic                               clk,
  input  logic                               rst,
  fmdc_cmd_if.sink                           cmd,
  fmdc_res_if.source                         res,
  input  logic                               cfg_wr_en,
  input  logic [fmdc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [fmdc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import fmdc_pkg::*;

  // Calibration and limit registers
  logic [23:0] pulses_per_unit_q16;
  logic [23:0] pulse_offset_q16;
  logic [15:0] units_per_pulse_q16;
  logic [31:0] timeout_us;
  logic [31:0] no_flow_after_us;

  // Stage links
  logic      prep_valid;
  prep_t     prep_data;
  logic      prep_ready;
  logic      core_valid;
  core_res_t core_data;
  logic      core_ready;

  // Register writes: indices beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      pulses_per_unit_q16 <= 24'd135242;
      pulse_offset_q16    <= 24'd250959;
      units_per_pulse_q16 <= 16'd31758;
      timeout_us          <= 32'd60000000;
      no_flow_after_us    <= 32'd20000000;
    end else if (cfg_wr_en) begin
      unique case (reg_index_t'(cfg_index))
        REG_PULSES_PER_UNIT: pulses_per_unit_q16 <= cfg_wdata[23:0];
        REG_PULSE_OFFSET:    pulse_offset_q16    <= cfg_wdata[23:0];
        REG_UNITS_PER_PULSE: units_per_pulse_q16 <= cfg_wdata[15:0];
        REG_TIMEOUT:         timeout_us          <= cfg_wdata;
        REG_NO_FLOW_AFTER:   no_flow_after_us    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Input register: hold the command and its scaled pulse target
  fmdc_prep u_prep (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .pulses_per_unit_q16 (pulses_per_unit_q16),
    .pulse_offset_q16    (pulse_offset_q16),
    .out_valid           (prep_valid),
    .out_data            (prep_data),
    .out_ready           (prep_ready)
  );

  // Decision stage: advance the run state, pick the end cause
  fmdc_core u_core (
    .clk              (clk),
    .rst              (rst),
    .timeout_us       (timeout_us),
    .no_flow_after_us (no_flow_after_us),
    .in_valid         (prep_valid),
    .in_data          (prep_data),
    .in_ready         (prep_ready),
    .out_valid        (core_valid),
    .out_data         (core_data),
    .out_ready        (core_ready)
  );

  // Output register: delivered volume and the result transfer
  fmdc_vol u_vol (
    .clk                 (clk),
    .rst                 (rst),
    .units_per_pulse_q16 (units_per_pulse_q16),
    .in_valid            (core_valid),
    .in_data             (core_data),
    .in_ready            (core_ready),
    .res                 (res)
  );
endmodule

>>> tb/flow_metered_dosing_controller_tb.sv
// ============================================================================
// flow_metered_dosing_controller_tb
// Self-checking bench for the dosing controller: a queue-fed driver pushes
// start, sample and abort commands through the valid/ready command channel,
// a predictor kept in step with every accepted transfer works out each
// result, and a monitor compares the result channel against it field by
// field. Calibration is rewritten between phases, extremes included.
// ============================================================================
module flow_metered_dosing_controller_tb;
  import fmdc_pkg::*;

  // Abandon the run after this many cycles without any transfer. A correct run
  // stalls only through 20% random idling on both sides plus a three-stage
  // pipeline, so this is generous.
  localparam int unsigned STALL_LIMIT = 2000;
  // Cycles to linger after the last result so that any stray result can surface.
  localparam int unsigned SETTLE_CYCLES = 8;

  // One command as the bench sees it
  typedef struct {
    op_t         op;
    logic [15:0] vol;
    logic        vsel;
    logic [15:0] win;
    logic [31:0] now;
  } dose_cmd_t;

  // One result as the bench expects it
  typedef struct {
    logic        driver_enable;
    logic        pump_on;
    logic        valve_a_open;
    logic        valve_b_open;
    logic        finished;
    status_t     status;
    logic [15:0] volume_delivered;
    logic [23:0] pulse_total;
  } dose_res_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  fmdc_cmd_if cmd_ch ();
  fmdc_res_if res_ch ();

  flow_metered_dosing_controller dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .res       (res_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Calibration copy, loaded with the block's reset values
  logic [23:0] cal_ppu = 24'd135242;
  logic [23:0] cal_offset = 24'd250959;
  logic [15:0] cal_upp = 16'd31758;
  logic [31:0] cal_timeout = 32'd60000000;
  logic [31:0] cal_no_flow = 32'd20000000;

  // Run state copy
  logic        run_active = 1'b0;
  logic        valve_b = 1'b0;
  logic [23:0] pulse_cnt = '0;
  logic [23:0] pulse_goal = '0;
  logic [31:0] t_start = '0;
  logic [31:0] t_elapsed = '0;

  dose_cmd_t cmd_backlog[$];
  dose_res_t owed_results[$];
  dose_cmd_t on_wire;
  dose_res_t head_result;
  logic [31:0] clock_us = '0;
  logic calm = 1'b0;
  int unsigned fail_cnt = 0;
  int unsigned stall_cycles = 0;

  // --------------------------------------------------------------------------
  // Dosing predictor: advance the run state by one command, return its result
  // --------------------------------------------------------------------------
  function automatic dose_res_t dose_predict(dose_cmd_t c);
    dose_res_t r;
    logic [39:0] scaled;
    logic [39:0] goal;
    logic [24:0] sum;
    logic [39:0] dose;
    logic dry;
    logic fin;
    status_t st;
    fin = 1'b0;
    st = ST_IGNORED;
    case (c.op)
      OP_START: begin
        if (!run_active) begin
          scaled = 40'(cal_ppu) * 40'(c.vol);
          goal = (scaled > 40'(cal_offset)) ? (scaled - 40'(cal_offset)) >> 16 : '0;
          valve_b = c.vsel;
          pulse_cnt = '0;
          pulse_goal = goal[23:0];
          t_start = c.now;
          t_elapsed = '0;
          // An empty target finishes at once, nothing opened
          if (goal == '0) begin
            run_active = 1'b0;
            fin = 1'b1;
            st = ST_TARGET;
          end else begin
            run_active = 1'b1;
            st = ST_NONE;
          end
        end
      end
      OP_SAMPLE: begin
        if (run_active) begin
          t_elapsed = c.now - t_start;
          dry = (c.win == '0) && (t_elapsed >= cal_no_flow);
          sum = {1'b0, pulse_cnt} + 25'(c.win);
          pulse_cnt = sum[24] ? 24'hFFFFFF : sum[23:0];
          // Target beats no flow, no flow beats timeout
          fin = 1'b1;
          if (pulse_cnt >= pulse_goal) begin
            st = ST_TARGET;
          end else if (dry) begin
            st = ST_NO_FLOW;
          end else if (t_elapsed >= cal_timeout) begin
            st = ST_TIMEOUT;
          end else begin
            fin = 1'b0;
            st = ST_NONE;
          end
          if (fin) run_active = 1'b0;
        end
      end
      OP_ABORT: begin
        if (run_active) begin
          run_active = 1'b0;
          fin = 1'b1;
          st = ST_ABORTED;
        end
      end
      default: ;
    endcase
    dose = 40'(pulse_cnt) * 40'(cal_upp);
    dose = dose >> 16;
    r.driver_enable = run_active;
    r.pump_on = run_active;
    r.valve_a_open = run_active && !valve_b;
    r.valve_b_open = run_active && valve_b;
    r.finished = fin;
    r.status = st;
    r.volume_delivered = !fin ? 16'd0 : (dose > 40'hFFFF) ? 16'hFFFF : dose[15:0];
    r.pulse_total = pulse_cnt;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Command driver: take the next queued command whenever the slot is free,
  // idle at random unless the calm stretch is on. Predict at the transfer.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) owed_results.push_back(dose_predict(on_wire));
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (cmd_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 20)) begin
          on_wire = cmd_backlog.pop_front();
          cmd_ch.valid <= 1'b1;
          cmd_ch.operation <= on_wire.op;
          cmd_ch.target_volume <= on_wire.vol;
          cmd_ch.valve_select <= on_wire.vsel;
          cmd_ch.window_pulses <= on_wire.win;
          cmd_ch.now_us <= on_wire.now;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: compare each transfer with the oldest owed result,
  // stall the block at random through ready.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (owed_results.size() == 0) begin
          $error("result transfer with no command outstanding");
          fail_cnt++;
        end else begin
          head_result = owed_results.pop_front();
          check_field("driver_enable", head_result.driver_enable, res_ch.driver_enable);
          check_field("pump_on", head_result.pump_on, res_ch.pump_on);
          check_field("valve_a_open", head_result.valve_a_open, res_ch.valve_a_open);
          check_field("valve_b_open", head_result.valve_b_open, res_ch.valve_b_open);
          check_field("finished", head_result.finished, res_ch.finished);
          check_field("status", head_result.status, res_ch.status);
          check_field("volume_delivered", head_result.volume_delivered,
                      res_ch.volume_delivered);
          check_field("pulse_total", head_result.pulse_total, res_ch.pulse_total);
        end
      end
      res_ch.ready <= calm || ($urandom_range(0, 99) >= 20);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: count cycles with no transfer on either channel
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_cmd(op_t op, logic [15:0] vol, logic vsel, logic [15:0] win,
                          logic [31:0] now);
    dose_cmd_t c;
    c.op = op;
    c.vol = vol;
    c.vsel = vsel;
    c.win = win;
    c.now = now;
    cmd_backlog.push_back(c);
  endtask

  // Write one calibration register; the caller drops the enable afterwards
  task automatic cfg_write(reg_index_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_PULSES_PER_UNIT: cal_ppu = val[23:0];
      REG_PULSE_OFFSET:    cal_offset = val[23:0];
      REG_UNITS_PER_PULSE: cal_upp = val[15:0];
      REG_TIMEOUT:         cal_timeout = val;
      REG_NO_FLOW_AFTER:   cal_no_flow = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [23:0] ppu, logic [23:0] off, logic [15:0] upp,
                                logic [31:0] tmo, logic [31:0] nf);
    cfg_write(REG_PULSES_PER_UNIT, 32'(ppu));
    cfg_write(REG_PULSE_OFFSET, 32'(off));
    cfg_write(REG_UNITS_PER_PULSE, 32'(upp));
    cfg_write(REG_TIMEOUT, tmo);
    cfg_write(REG_NO_FLOW_AFTER, nf);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Hold until every queued command has gone and every result has come back
  task automatic drain();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || cmd_ch.valid || owed_results.size() != 0);
  endtask

  // Mostly well-formed runs with random content; the rest is noise, stray
  // starts in the middle of a run and aborts. Close any open run at the end.
  task automatic gen_batch(int unsigned n);
    int unsigned made;
    int unsigned len;
    logic [31:0] dt;
    logic [15:0] win;
    logic [15:0] vol;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 9) == 0) begin
        push_cmd(op_t'($urandom_range(0, 3)), 16'($urandom), 1'($urandom),
                 16'($urandom), $urandom);
        made++;
      end else begin
        if ($urandom_range(0, 15) == 0) clock_us = $urandom;
        vol = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
        push_cmd(OP_START, vol, 1'($urandom), 16'($urandom), clock_us);
        made++;
        len = $urandom_range(1, 12);
        repeat (len) begin
          case ($urandom_range(0, 9))
            0:       dt = $urandom;
            1, 2:    dt = $urandom_range(0, 40000000);
            default: dt = $urandom_range(0, 200000);
          endcase
          clock_us += dt;
          case ($urandom_range(0, 19))
            0, 1, 2, 3: win = '0;
            4:          win = 16'hFFFF;
            default:    win = 16'($urandom_range(0, 1 << $urandom_range(0, 15)));
          endcase
          if ($urandom_range(0, 9) == 0) begin
            push_cmd(OP_START, 16'($urandom), 1'($urandom), 16'($urandom), clock_us);
            made++;
          end
          push_cmd(OP_SAMPLE, 16'($urandom), 1'($urandom), win, clock_us);
          made++;
        end
        if ($urandom_range(0, 4) == 0) begin
          push_cmd(OP_ABORT, 16'($urandom), 1'($urandom), 16'($urandom), clock_us);
          made++;
        end
      end
    end
    push_cmd(OP_ABORT, '0, 1'b0, '0, clock_us);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.operation = '0;
    cmd_ch.target_volume = '0;
    cmd_ch.valve_select = 1'b0;
    cmd_ch.window_pulses = '0;
    cmd_ch.now_us = '0;
    res_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part, reset calibration (about 2.06 pulses per unit)
    // Commands while idle are ignored, unused code included
    push_cmd(OP_SAMPLE, 16'hFFFF, 1'b1, 16'hFFFF, 32'hFFFFFFFF);
    push_cmd(OP_ABORT, '0, 1'b0, '0, '0);
    push_cmd(OP_UNUSED, 16'hFFFF, 1'b1, 16'hFFFF, 32'hFFFFFFFF);
    // Empty targets: zero volume and a volume below the offset
    push_cmd(OP_START, 16'd0, 1'b0, '0, 32'd0);
    push_cmd(OP_START, 16'd2, 1'b1, '0, 32'd7);
    // Two-pulse run across the timestamp wrap, stray start and unused code
    push_cmd(OP_START, 16'd3, 1'b1, '0, 32'hFFFFFF00);
    push_cmd(OP_START, 16'hFFFF, 1'b0, '0, 32'hFFFFFF10);
    push_cmd(OP_UNUSED, '0, 1'b0, '0, 32'hFFFFFF20);
    push_cmd(OP_SAMPLE, '0, 1'b0, 16'd0, 32'h00000100);
    push_cmd(OP_SAMPLE, '0, 1'b0, 16'd1, 32'h00000200);
    push_cmd(OP_SAMPLE, '0, 1'b0, 16'hFFFF, 32'h00000300);
    // Largest volume, then an empty window past the no-flow delay
    push_cmd(OP_START, 16'hFFFF, 1'b0, '0, 32'd1000);
    push_cmd(OP_SAMPLE, '0, 1'b0, 16'hFFFF, 32'd2000);
    push_cmd(OP_SAMPLE, '0, 1'b0, 16'd0, 32'd20001000);
    // Timeout with flow still coming
    push_cmd(OP_START, 16'd100, 1'b1, '0, 32'd5000);
    push_cmd(OP_SAMPLE, '0, 1'b0, 16'd5, 32'd60005000);
    // No flow and timeout together: no flow wins
    push_cmd(OP_START, 16'd100, 1'b0, '0, 32'd0);
    push_cmd(OP_SAMPLE, '0, 1'b0, 16'd0, 32'd60000000);
    // Target and timeout together: target wins
    push_cmd(OP_START, 16'd10, 1'b1, '0, 32'd0);
    push_cmd(OP_SAMPLE, '0, 1'b0, 16'd20, 32'd70000000);
    // Abort, then a sample that finds the block idle
    push_cmd(OP_START, 16'd50, 1'b0, '0, 32'd123);
    push_cmd(OP_ABORT, '0, 1'b0, '0, 32'd200);
    push_cmd(OP_SAMPLE, '0, 1'b0, 16'd9, 32'd300);
    drain();

    // Reset values written back explicitly
    apply_settings(24'd135242, 24'd250959, 16'd31758, 32'd60000000, 32'd20000000);
    gen_batch(150);
    drain();

    // Upper extremes; drive the pulse count into saturation on the way
    apply_settings(24'hFFFFFF, 24'd0, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    clock_us = 32'd50;
    push_cmd(OP_START, 16'hFFFF, 1'b1, '0, clock_us);
    repeat (255) begin
      clock_us += 32'd1000;
      push_cmd(OP_SAMPLE, '0, 1'b0, 16'hFFFF, clock_us);
    end
    push_cmd(OP_SAMPLE, '0, 1'b0, 16'd64575, clock_us + 32'd1000);
    push_cmd(OP_SAMPLE, '0, 1'b0, 16'hFFFF, clock_us + 32'd2000);
    gen_batch(60);
    drain();

    // Lower extremes: no gain, full offset, so every start is an empty target
    apply_settings(24'd0, 24'hFFFFFF, 16'd0, 32'd1, 32'd0);
    gen_batch(30);
    drain();

    // Zero timeout: a run ends on its first sample, by timeout unless target or no flow wins
    apply_settings(24'h010000, 24'd0, 16'h8000, 32'd0, 32'd1000);
    push_cmd(OP_START, 16'd100, 1'b0, '0, 32'd4000);
    push_cmd(OP_SAMPLE, '0, 1'b0, 16'd1, 32'd4000);
    gen_batch(120);
    drain();

    // Random calibration with short delays so timeouts and dry windows occur
    apply_settings(24'($urandom_range(32'h4000, 32'h60000)), 24'($urandom),
                   16'($urandom), $urandom_range(1, 3000000), $urandom_range(0, 1000000));
    gen_batch(150);
    drain();

    // Same again with no idling on either side
    apply_settings(24'($urandom_range(32'h4000, 32'h60000)), 24'($urandom),
                   16'($urandom), $urandom_range(1, 3000000), $urandom_range(0, 1000000));
    calm = 1'b1;
    gen_batch(150);
    drain();
    calm = 1'b0;

    // Let any stray result surface before the verdict
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && owed_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
